FILE: design/mlm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multichannel level meter.
// Holds the register map, the sequencer state type and fixed field widths.
// Depends on nothing else.

package mlm_pkg;

  // Configuration port widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register field widths
  localparam int CHANNEL_COUNT_W = 4;
  localparam int FRAMES_W        = 13;
  localparam int FACTOR_W        = 16;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHANNEL_COUNT    = 2'd0,
    CFG_FRAMES_PER_BLOCK = 2'd1,
    CFG_SMOOTHING_FACTOR = 2'd2
  } cfg_index_t;

  // Register values after reset
  localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET    = 4'd2;
  localparam logic [FRAMES_W-1:0]        FRAMES_PER_BLOCK_RESET = 13'd32;
  localparam logic [FACTOR_W-1:0]        SMOOTHING_FACTOR_RESET = 16'd210;

  // Rounding term of the Q0.16 smoothing product
  localparam logic [FACTOR_W-1:0] FACTOR_ROUND = 16'h8000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_READ,
    ST_LOAD,
    ST_DIVIDE,
    ST_SCALE,
    ST_UPDATE
  } state_t;

endpackage

FILE: design/multichannel_level_meter.sv
`timescale 1ns / 1ps
// Top level of the multichannel level meter: accumulation, block-end sequencer,
// divider and smoothing datapath, with per-channel state held in two memories.
// Depends on mlm_pkg.

// Interleaved signed samples are taken one per clock while a block is being
// gathered; each beat adds the sample's magnitude into its channel's entry of the
// sum memory by read, add and write-back, with forwarding when two beats in a
// row hit the same channel. When the last sample of a block is taken, the input
// stalls while a sequencer walks the active channels in order: it reads the sum
// and the stored average and peak, divides the sum by the frames taken with a
// shared divider that yields one quotient bit per cycle, applies the Q0.16
// smoothing step and writes the new average and peak back. A flush state opens
// the block end; each channel then passes through the read, load, divide, scale
// and update states, waiting in update while the result side stalls, and one
// result beat per channel leaves through an output register, the final one
// marked last. The sums restart from zero after every block; averages and peaks
// clear only on reset. Configuration is taken on any cycle and should be written
// while idle.

module multichannel_level_meter #(
  parameter int CHANNELS    = 8,
  parameter int MAX_FRAMES  = 4096,
  parameter int SAMPLE_BITS = 24,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mlm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mlm_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Sample input
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  // Result output
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [CH_W-1:0]                      channel_index,
  output logic [SAMPLE_BITS-1:0]               block_level,
  output logic [SAMPLE_BITS-1:0]               average_level,
  output logic [SAMPLE_BITS-1:0]               peak_level,
  output logic                                 last_channel
);

  localparam int LEVEL_W = SAMPLE_BITS;
  localparam int FP_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = FP_W + 1;
  localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_FRAMES);
  localparam int NCH_W   = $clog2(CHANNELS + 1);
  localparam int NFR_W   = $clog2(MAX_FRAMES + 1);
  localparam int DC_W    = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam int PROD_W  = mlm_pkg::FACTOR_W + LEVEL_W + 1;

  // Configuration registers
  logic [mlm_pkg::CHANNEL_COUNT_W-1:0] channel_count;
  logic [mlm_pkg::FRAMES_W-1:0]        frames_per_block;
  logic [mlm_pkg::FACTOR_W-1:0]        smoothing_factor;

  // Position counters and sequencer
  logic [CH_W-1:0]        chan_pos, chan_pos_next;
  logic [FP_W-1:0]        frame_pos, frame_pos_next;
  logic [CNT_W-1:0]       frame_count;
  mlm_pkg::state_t        state, state_next;
  logic [CH_W-1:0]        drain_ch;

  // Accumulation pipeline
  logic                   b_valid;
  logic [CH_W-1:0]        b_ch;
  logic [SAMPLE_BITS-1:0] b_mag;
  logic                   fwd_valid;
  logic [CH_W-1:0]        fwd_ch;
  logic [SUM_W-1:0]       fwd_sum;

  // Memories and their read registers
  logic [SUM_W-1:0]       sum_mem [CHANNELS];
  logic [2*LEVEL_W-1:0]   lvl_mem [CHANNELS];
  logic [CHANNELS-1:0]    sum_valid;
  logic [CHANNELS-1:0]    lvl_valid;
  logic [SUM_W-1:0]       sum_rd;
  logic                   sum_rd_valid;
  logic [2*LEVEL_W-1:0]   lvl_rd;
  logic                   lvl_rd_valid;

  // Divider and smoothing datapath
  logic [SUM_W-1:0]       div_num;
  logic [CNT_W-1:0]       div_rem;
  logic [LEVEL_W-1:0]     quot;
  logic [DC_W-1:0]        div_cnt;
  logic [LEVEL_W-1:0]     avg_reg;
  logic [LEVEL_W-1:0]     peak_reg;
  logic [LEVEL_W-1:0]     step_reg;
  logic                   up_reg;

  // Combinational signals
  logic [NCH_W-1:0]       nch;
  logic [NFR_W-1:0]       nfr;
  logic                   accept;
  logic                   chan_wrap;
  logic                   frame_wrap;
  logic                   block_end;
  logic [SAMPLE_BITS-1:0] mag;
  logic [CH_W-1:0]        sum_raddr;
  logic [SUM_W-1:0]       sum_base;
  logic [SUM_W-1:0]       sum_new;
  logic [CNT_W:0]         div_shift;
  logic                   div_take;
  logic                   div_done;
  logic [LEVEL_W-1:0]     diff;
  logic [PROD_W-1:0]      prod;
  logic [LEVEL_W-1:0]     avg_new;
  logic [LEVEL_W-1:0]     peak_new;
  logic                   out_free;
  logic                   drain_last;
  logic                   load_result;

  assign cfg_ready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= mlm_pkg::CHANNEL_COUNT_RESET;
      frames_per_block <= mlm_pkg::FRAMES_PER_BLOCK_RESET;
      smoothing_factor <= mlm_pkg::SMOOTHING_FACTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlm_pkg::CFG_CHANNEL_COUNT:
          channel_count <= cfg_data[mlm_pkg::CHANNEL_COUNT_W-1:0];
        mlm_pkg::CFG_FRAMES_PER_BLOCK:
          frames_per_block <= cfg_data[mlm_pkg::FRAMES_W-1:0];
        mlm_pkg::CFG_SMOOTHING_FACTOR:
          smoothing_factor <= cfg_data[mlm_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective channel and frame counts, with zero read as one and clamping above
  always_comb begin
    if (channel_count == '0) begin
      nch = NCH_W'(1);
    end else if (32'(channel_count) > CHANNELS) begin
      nch = NCH_W'(CHANNELS);
    end else begin
      nch = NCH_W'(channel_count);
    end
    if (frames_per_block == '0) begin
      nfr = NFR_W'(1);
    end else if (32'(frames_per_block) > MAX_FRAMES) begin
      nfr = NFR_W'(MAX_FRAMES);
    end else begin
      nfr = NFR_W'(frames_per_block);
    end
  end

  // Frame and block boundaries of the beat being taken
  assign accept     = sample_valid && !sample_stall;
  assign chan_wrap  = (32'(chan_pos) + 32'd1) >= 32'(nch);
  assign frame_wrap = (32'(frame_pos) + 32'd1) >= 32'(nfr);
  assign block_end  = chan_wrap && frame_wrap;
  assign mag        = sample[SAMPLE_BITS-1] ? $unsigned(-sample) : $unsigned(sample);

  always_comb begin
    chan_pos_next  = chan_pos;
    frame_pos_next = frame_pos;
    if (accept) begin
      if (!chan_wrap) begin
        chan_pos_next = chan_pos + CH_W'(1);
      end else begin
        chan_pos_next  = '0;
        frame_pos_next = frame_wrap ? '0 : frame_pos + FP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_pos  <= '0;
      frame_pos <= '0;
    end else begin
      chan_pos  <= chan_pos_next;
      frame_pos <= frame_pos_next;
    end
  end

  // Frames taken in the block, kept as the divisor for the block end
  always_ff @(posedge clk) begin
    if (accept && block_end) begin
      frame_count <= CNT_W'(frame_pos) + CNT_W'(1);
    end
  end

  // Second accumulation stage: add the magnitude to the stored sum
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      b_valid   <= accept;
      fwd_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_ch    <= chan_pos;
    b_mag   <= mag;
    fwd_ch  <= b_ch;
    fwd_sum <= sum_new;
  end

  // A write-back of the previous cycle is not yet visible in the read data
  always_comb begin
    if (fwd_valid && (fwd_ch == b_ch)) begin
      sum_base = fwd_sum;
    end else if (sum_rd_valid) begin
      sum_base = sum_rd;
    end else begin
      sum_base = '0;
    end
    sum_new = sum_base + SUM_W'(b_mag);
  end

  // Sum memory
  assign sum_raddr = (state == mlm_pkg::ST_IDLE) ? chan_pos : drain_ch;

  always_ff @(posedge clk) begin
    if (b_valid) begin
      sum_mem[b_ch] <= sum_new;
    end
    sum_rd <= sum_mem[sum_raddr];
  end

  // Sum entries count as zero until written in the current block
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid    <= '0;
      sum_rd_valid <= 1'b0;
    end else begin
      sum_rd_valid <= sum_valid[sum_raddr];
      if (load_result && drain_last) begin
        sum_valid <= '0;
      end else if (b_valid) begin
        sum_valid[b_ch] <= 1'b1;
      end
    end
  end

  // Level memory: smoothed average in the upper half, peak in the lower half
  always_ff @(posedge clk) begin
    if (load_result) begin
      lvl_mem[drain_ch] <= {avg_new, peak_new};
    end
    lvl_rd <= lvl_mem[drain_ch];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid    <= '0;
      lvl_rd_valid <= 1'b0;
    end else begin
      lvl_rd_valid <= lvl_valid[drain_ch];
      if (load_result) begin
        lvl_valid[drain_ch] <= 1'b1;
      end
    end
  end

  // Restoring divider step: one quotient bit per cycle
  assign div_shift = {div_rem, div_num[SUM_W-1]};
  assign div_take  = div_shift >= {1'b0, frame_count};
  assign div_done  = div_cnt == DC_W'(SUM_W - 1);

  always_ff @(posedge clk) begin
    if (state == mlm_pkg::ST_LOAD) begin
      div_num  <= sum_rd_valid ? sum_rd : '0;
      div_rem  <= '0;
      div_cnt  <= '0;
      avg_reg  <= lvl_rd_valid ? lvl_rd[2*LEVEL_W-1:LEVEL_W] : '0;
      peak_reg <= lvl_rd_valid ? lvl_rd[LEVEL_W-1:0] : '0;
    end else if (state == mlm_pkg::ST_DIVIDE) begin
      div_num <= {div_num[SUM_W-2:0], 1'b0};
      div_rem <= div_take ? CNT_W'(div_shift - {1'b0, frame_count}) : div_shift[CNT_W-1:0];
      quot    <= {quot[LEVEL_W-2:0], div_take};
      div_cnt <= div_cnt + DC_W'(1);
    end
  end

  // Smoothing step: rounded Q0.16 fraction of the distance to the block mean
  assign diff = (quot >= avg_reg) ? (quot - avg_reg) : (avg_reg - quot);
  assign prod = PROD_W'(smoothing_factor) * PROD_W'(diff) + PROD_W'(mlm_pkg::FACTOR_ROUND);

  always_ff @(posedge clk) begin
    if (state == mlm_pkg::ST_SCALE) begin
      step_reg <= prod[mlm_pkg::FACTOR_W +: LEVEL_W];
      up_reg   <= quot >= avg_reg;
    end
  end

  assign avg_new  = up_reg ? (avg_reg + step_reg) : (avg_reg - step_reg);
  assign peak_new = (quot > peak_reg) ? quot : peak_reg;

  // Sequencer control
  assign out_free   = !result_valid || !result_stall;
  assign drain_last = (32'(drain_ch) + 32'd1) >= 32'(nch);

  always_comb begin
    sample_stall = state != mlm_pkg::ST_IDLE;
    load_result  = (state == mlm_pkg::ST_UPDATE) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mlm_pkg::ST_IDLE:   if (accept && block_end) state_next = mlm_pkg::ST_FLUSH;
      mlm_pkg::ST_FLUSH:  state_next = mlm_pkg::ST_READ;
      mlm_pkg::ST_READ:   state_next = mlm_pkg::ST_LOAD;
      mlm_pkg::ST_LOAD:   state_next = mlm_pkg::ST_DIVIDE;
      mlm_pkg::ST_DIVIDE: if (div_done) state_next = mlm_pkg::ST_SCALE;
      mlm_pkg::ST_SCALE:  state_next = mlm_pkg::ST_UPDATE;
      mlm_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = drain_last ? mlm_pkg::ST_IDLE : mlm_pkg::ST_READ;
        end
      end
      default:            state_next = mlm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mlm_pkg::ST_IDLE;
      drain_ch <= '0;
    end else begin
      state <= state_next;
      if (state == mlm_pkg::ST_FLUSH) begin
        drain_ch <= '0;
      end else if (load_result) begin
        drain_ch <= drain_ch + CH_W'(1);
      end
    end
  end

  // Output register: one result beat per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      channel_index <= drain_ch;
      block_level   <= quot;
      average_level <= avg_new;
      peak_level    <= peak_new;
      last_channel  <= drain_last;
    end
  end

endmodule

FILE: tb/mlm_level_checker.sv
`timescale 1ns / 1ps
// Checker for the multichannel level meter: follows register writes and sample
// beats, predicts every result beat and compares it field by field.
// Depends on mlm_pkg.

module mlm_level_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mlm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mlm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  logic [23:0]                     sample,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [2:0]                      channel_index,
  input  logic [23:0]                     block_level,
  input  logic [23:0]                     average_level,
  input  logic [23:0]                     peak_level,
  input  logic                            last_channel,
  output int                              mismatch_count,
  output int                              pending_results
);

  localparam int CHANNELS   = 8;
  localparam int MAX_FRAMES = 4096;

  // One predicted result beat.
  typedef struct packed {
    logic [2:0]  chan;
    logic [23:0] block;
    logic [23:0] average;
    logic [23:0] peak;
    logic        last;
  } level_result_t;

  level_result_t level_q[$];

  // Shadow copy of the registers and of the per-channel state.
  logic [mlm_pkg::CHANNEL_COUNT_W-1:0] chan_count_reg;
  logic [mlm_pkg::FRAMES_W-1:0]        frames_reg;
  logic [mlm_pkg::FACTOR_W-1:0]        factor_reg;
  logic [35:0]                         chan_sum  [CHANNELS];
  logic [23:0]                         avg_level [CHANNELS];
  logic [23:0]                         peak_hold [CHANNELS];
  int unsigned                         chan_pos;
  int unsigned                         frame_pos;

  int fail_tally    = 0;
  int pending_tally = 0;

  assign mismatch_count  = fail_tally;
  assign pending_results = pending_tally;

  // Zero and out-of-range channel counts are clamped to 1..CHANNELS.
  function automatic int unsigned active_channels();
    if (chan_count_reg == 0) return 1;
    if (chan_count_reg > CHANNELS) return CHANNELS;
    return chan_count_reg;
  endfunction

  // Zero and out-of-range frame counts are clamped to 1..MAX_FRAMES.
  function automatic int unsigned active_frames();
    if (frames_reg == 0) return 1;
    if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
    return frames_reg;
  endfunction

  // Absolute value of a two's complement sample; the most negative value maps to 2^23.
  function automatic logic [23:0] sample_magnitude(input logic [23:0] raw);
    logic [24:0] negated;
    negated = 25'h1000000 - {1'b0, raw};
    return raw[23] ? negated[23:0] : raw;
  endfunction

  // Move the average towards the block level by the rounded Q0.16 fraction of the gap.
  function automatic logic [23:0] eased_level(input logic [23:0] prev,
                                              input logic [23:0] target,
                                              input logic [15:0] weight);
    logic [23:0] gap;
    logic [63:0] stride;
    gap    = (target >= prev) ? target - prev : prev - target;
    stride = (64'(weight) * 64'(gap) + 64'd32768) >> 16;
    return (target >= prev) ? prev + stride[23:0] : prev - stride[23:0];
  endfunction

  task automatic clear_levels();
    for (int c = 0; c < CHANNELS; c++) begin
      chan_sum[c]  = '0;
      avg_level[c] = '0;
      peak_hold[c] = '0;
    end
    chan_pos       = 0;
    frame_pos      = 0;
    chan_count_reg = mlm_pkg::CHANNEL_COUNT_RESET;
    frames_reg     = mlm_pkg::FRAMES_PER_BLOCK_RESET;
    factor_reg     = mlm_pkg::SMOOTHING_FACTOR_RESET;
    level_q.delete();
  endtask

  task automatic apply_write(input logic [mlm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mlm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mlm_pkg::CFG_CHANNEL_COUNT:
        chan_count_reg = data[mlm_pkg::CHANNEL_COUNT_W-1:0];
      mlm_pkg::CFG_FRAMES_PER_BLOCK:
        frames_reg = data[mlm_pkg::FRAMES_W-1:0];
      mlm_pkg::CFG_SMOOTHING_FACTOR:
        factor_reg = data[mlm_pkg::FACTOR_W-1:0];
      default: ;
    endcase
  endtask

  // Accumulate one sample and, at the end of a block, queue one result per channel.
  task automatic take_sample(input logic [23:0] raw);
    int unsigned   nch;
    int unsigned   nfr;
    logic [35:0]   frames_taken;
    logic [35:0]   quotient;
    logic [23:0]   mean;
    level_result_t want;
    nch = active_channels();
    nfr = active_frames();
    chan_sum[chan_pos] = chan_sum[chan_pos] + 36'(sample_magnitude(raw));
    if (chan_pos + 1 < nch) begin
      chan_pos++;
    end else begin
      chan_pos = 0;
      if (frame_pos + 1 < nfr) begin
        frame_pos++;
      end else begin
        frames_taken = 36'(frame_pos + 1);
        frame_pos    = 0;
        for (int c = 0; c < nch; c++) begin
          quotient = chan_sum[c] / frames_taken;
          mean     = (quotient > 36'hFFFFFF) ? 24'hFFFFFF : quotient[23:0];
          avg_level[c] = eased_level(avg_level[c], mean, factor_reg);
          if (mean > peak_hold[c]) peak_hold[c] = mean;
          want.chan    = 3'(c);
          want.block   = mean;
          want.average = avg_level[c];
          want.peak    = peak_hold[c];
          want.last    = (c + 1 == nch);
          level_q.push_back(want);
        end
        for (int c = 0; c < CHANNELS; c++) chan_sum[c] = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_tally++;
    end
  endtask

  task automatic check_result();
    level_result_t want;
    if (level_q.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual channel %0d %0d/%0d/%0d",
               $time, channel_index, block_level, average_level, peak_level);
      fail_tally++;
    end else begin
      want = level_q.pop_front();
      check_field("channel_index", 24'(want.chan), 24'(channel_index));
      check_field("block_level", want.block, block_level);
      check_field("average_level", want.average, average_level);
      check_field("peak_level", want.peak, peak_level);
      check_field("last_channel", 24'(want.last), 24'(last_channel));
    end
  endtask

  // Every handshake is seen at the rising edge; results of earlier blocks come first.
  always @(posedge clk) begin
    if (rst) begin
      clear_levels();
    end else begin
      if (result_valid && !result_stall) check_result();
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (sample_valid && !sample_stall) take_sample(sample);
    end
    pending_tally = level_q.size();
  end

endmodule

FILE: tb/tb_multichannel_level_meter.sv
`timescale 1ns / 1ps
// Testbench top for the multichannel level meter: drives samples, register writes
// and result back-pressure, and reports the verdict of the level checker.
// Depends on mlm_pkg, multichannel_level_meter and mlm_level_checker.

module tb_multichannel_level_meter;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_CYCLES  = 400;
  localparam int RANDOM_ITEMS  = 260;

  // Index past the end of the register map; writes to it must be ignored.
  localparam logic [mlm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h800000;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            cfg_valid    = 1'b0;
  logic [mlm_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [mlm_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                            sample_valid = 1'b0;
  logic signed [23:0]              sample       = '0;
  logic                            result_stall = 1'b0;

  logic        cfg_ready;
  logic        sample_stall;
  logic        result_valid;
  logic [2:0]  channel_index;
  logic [23:0] block_level;
  logic [23:0] average_level;
  logic [23:0] peak_level;
  logic        last_channel;

  int mismatch_count;
  int pending_results;
  bit gaps_on      = 1'b0;
  int stall_left   = 0;
  int cycle_count  = 0;
  int random_items = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multichannel_level_meter DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .channel_index (channel_index),
    .block_level   (block_level),
    .average_level (average_level),
    .peak_level    (peak_level),
    .last_channel  (last_channel)
  );

  mlm_level_checker level_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample          (sample),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .channel_index   (channel_index),
    .block_level     (block_level),
    .average_level   (average_level),
    .peak_level      (peak_level),
    .last_channel    (last_channel),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Result back-pressure comes in random bursts while gaps are enabled.
  always @(negedge clk) begin
    if (gaps_on && stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 14);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multichannel_level_meter test failed");
      $finish;
    end
  end

  // Mostly full-range noise, with the extremes and small values near zero mixed in.
  function automatic logic [23:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return 24'd0;
      3:       return 24'($urandom_range(0, 31)) ^ {24{$urandom_range(0, 1) == 1}};
      default: return 24'($urandom);
    endcase
  endfunction

  // Present one sample beat, with an optional gap first, and hold it until taken.
  task automatic send_sample(input logic [23:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  // Stop sending, wait for every predicted result and let the block go quiet.
  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mlm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mlm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all three registers; bits above each field carry random filler.
  task automatic configure(input logic [3:0] ch, input logic [12:0] frames,
                           input logic [15:0] factor);
    logic [15:0] filler;
    filler = 16'($urandom);
    write_reg(mlm_pkg::CFG_CHANNEL_COUNT, {filler[15:4], ch});
    write_reg(mlm_pkg::CFG_FRAMES_PER_BLOCK, {filler[15:13], frames});
    write_reg(mlm_pkg::CFG_SMOOTHING_FACTOR, factor);
  endtask

  initial begin
    int          n;
    logic [15:0] word;
    repeat (6) @(negedge clk);
    rst     <= 1'b0;
    gaps_on = 1'b1;

    // Register values straight out of reset: two channels, 32 frames.
    repeat (64) send_sample(random_sample());
    random_items += 64;
    settle();

    // One-sample blocks at full smoothing weight, then with the average frozen.
    configure(4'd1, 13'd1, 16'hFFFF);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'd0);
    send_sample(24'hFFFFFF);
    settle();
    write_reg(mlm_pkg::CFG_SMOOTHING_FACTOR, 16'd0);
    send_sample(24'd1);
    send_sample(SAMPLE_MIN);
    settle();

    // Zero channel and frame counts behave as one.
    configure(4'd0, 13'd0, 16'd32768);
    send_sample(24'd12345);
    send_sample(SAMPLE_MAX);
    settle();

    // Stop part-way through a block, shrink the channel count, then finish it.
    configure(4'd3, 13'd2, 16'd32768);
    repeat (5) send_sample(random_sample());
    settle();
    write_reg(mlm_pkg::CFG_CHANNEL_COUNT, 16'd2);
    write_reg(CFG_SPARE_INDEX, 16'($urandom));
    send_sample(random_sample());
    settle();

    // Channel count above the maximum saturates to eight.
    configure(4'd9, 13'd1, 16'd210);
    repeat (8) send_sample(random_sample());
    settle();

    // A block at full scale, then part of a block under an oversized frame count,
    // closed early by shrinking the frame count below the frames already taken.
    configure(4'd1, 13'd8, 16'd6554);
    repeat (8) send_sample(SAMPLE_MIN);
    settle();
    write_reg(mlm_pkg::CFG_FRAMES_PER_BLOCK, 16'hFFFF);
    repeat (6) send_sample(random_sample());
    settle();
    write_reg(mlm_pkg::CFG_FRAMES_PER_BLOCK, 16'd2);
    send_sample(random_sample());
    settle();

    // Random phases, each with a fresh subset of registers; blocks may straddle phases.
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        word = 16'($urandom);
        word[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 8));
        write_reg(mlm_pkg::CFG_CHANNEL_COUNT, word);
      end
      if ($urandom_range(0, 3) != 0) begin
        word = 16'($urandom);
        word[12:0] = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(6, 24))
                                                  : 13'($urandom_range(0, 5));
        write_reg(mlm_pkg::CFG_FRAMES_PER_BLOCK, word);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       word = 16'd0;
          1:       word = 16'hFFFF;
          default: word = 16'($urandom);
        endcase
        write_reg(mlm_pkg::CFG_SMOOTHING_FACTOR, word);
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE_INDEX, 16'($urandom));
      n = $urandom_range(4, 48);
      repeat (n) send_sample(random_sample());
      random_items += n;
      settle();
    end

    // Closing stretch at full rate on both sides.
    gaps_on = 1'b0;
    configure(4'd8, 13'd2, 16'd50000);
    repeat (16) send_sample(random_sample());
    sample_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("multichannel_level_meter test passed");
    end else begin
      $display("multichannel_level_meter test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mlm_pkg.sv
design/multichannel_level_meter.sv
tb/mlm_level_checker.sv
tb/tb_multichannel_level_meter.sv
